@@ rtl/rotate_point_about_axis_defines.svh @@
// Assertion macros for the checker file of the rotation block.
`ifndef ROTATE_POINT_ABOUT_AXIS_DEFINES_SVH
`define ROTATE_POINT_ABOUT_AXIS_DEFINES_SVH

// Clocked check, quiet while reset is asserted.
`define RPAA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked check that also holds through reset.
`define RPAA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

@@ rtl/rpaa_pkg.sv @@
// Package: types, constants and rounding helper for the axis rotation block.
`timescale 1ns / 1ps
`default_nettype none

package rpaa_pkg;

    // Port layout
    localparam int COMP_W      = 32;
    localparam int ANGLE_W     = 16;
    localparam int IN_TDATA_W  = 6 * COMP_W + ANGLE_W;
    localparam int OUT_TDATA_W = 3 * COMP_W;
    localparam int OUT_TUSER_W = 1;

    // CORDIC sine/cosine
    localparam int N_CORDIC  = 30;
    localparam int CORDIC_W  = 34;
    localparam int REM_W     = 14;
    localparam int Z_SHIFT   = 16;
    localparam int Q30_FRAC  = 30;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] ONE_Q30     = 34'sd1073741824;

    // Arc tangents in units of 1/2^32 turn
    localparam logic signed [31:0] ATAN_TURNS [0:N_CORDIC-1] = '{
        32'sh2000_0000, 32'sh12E4_051E, 32'sh09FB_385B, 32'sh0511_11D4,
        32'sh028B_0D43, 32'sh0145_D7E1, 32'sh00A2_F61E, 32'sh0051_7C55,
        32'sh0028_BE53, 32'sh0014_5F2F, 32'sh000A_2F98, 32'sh0005_17CC,
        32'sh0002_8BE6, 32'sh0001_45F3, 32'sh0000_A2F9, 32'sh0000_517C,
        32'sh0000_28BE, 32'sh0000_145F, 32'sh0000_0A2F, 32'sh0000_0517,
        32'sh0000_028B, 32'sh0000_0145, 32'sh0000_00A2, 32'sh0000_0051,
        32'sh0000_0028, 32'sh0000_0014, 32'sh0000_000A, 32'sh0000_0005,
        32'sh0000_0002, 32'sh0000_0001
    };

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } t_quad;

    // Datapath widths that do not depend on the trig precision
    localparam int KV_W     = 2 * COMP_W;       // k_i * v_j
    localparam int CR_W     = KV_W + 1;         // cross product, Q46
    localparam int CR_LO_W  = 33;               // low slice of cross for split multiply
    localparam int DOT_SH   = 16;
    localparam int DT_W     = KV_W - DOT_SH;    // rounded dot term, Q30
    localparam int DOT_W    = DT_W + 2;         // sum of three terms
    localparam int OUT_SH   = 14;               // Q30 -> Q16

    localparam logic [COMP_W-1:0] Q16_MAX = 32'h7FFF_FFFF;
    localparam logic [COMP_W-1:0] Q16_MIN = 32'h8000_0000;

    // Wide working type for shifts and rounding
    localparam int WIDE_W = 96;
    typedef logic signed [WIDE_W-1:0] t_wide;

    // p / 2^sh rounded to nearest, ties away from zero
    function automatic t_wide f_round_away(input t_wide p, input int unsigned sh);
        t_wide half;
        t_wide neg;
        half = t_wide'(1) << (sh - 1);
        neg  = t_wide'(p[WIDE_W-1]);
        return (p + half - neg) >>> sh;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rotate_point_about_axis.sv @@
// Top level: pipelined rotation of a Q16.16 point about a unit axis (Rodrigues form).
`timescale 1ns / 1ps
`default_nettype none

//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+--------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata: axis xyz, point xyz, angle
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: out xyz; tuser: saturated
//
//  One word per cycle in and out while m_axis is not stalled. A word passes one input
//  register, 30 CORDIC iteration stages and ten arithmetic stages before m_axis.
//  Most of the stages are the CORDIC chain, one iteration per register stage.
//  Reset (i_rst_n low, synchronous) clears only the stage valid bits.
//  Each stage holds when it is full and the one after it cannot move, so bubbles
//  collapse and s_axis keeps accepting while a finished word waits on m_axis until every stage is full.

module rotate_point_about_axis
    import rpaa_pkg::*;
#(
    parameter int TRIG_BITS = 10
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // s_axis tdata, low bit up: axis_x[31:0], axis_y[31:0], axis_z[31:0],
    // point_x[31:0], point_y[31:0], point_z[31:0], angle[15:0]
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire  [IN_TDATA_W-1:0]   s_axis_tdata,
    // m_axis tdata, low bit up: out_x[31:0], out_y[31:0], out_z[31:0]
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    // m_axis tuser: saturated[0]
    output logic [OUT_TUSER_W-1:0]  m_axis_tuser
);

    // ---------------------------------------------------------------------
    // Widths that follow from the trig precision
    // ---------------------------------------------------------------------
    localparam int CS_W    = TRIG_BITS + 2;                 // cos/sin, Q1.TRIG_BITS
    localparam int OM_W    = TRIG_BITS + 3;                 // 1 - cos
    localparam int TRIG_SH = Q30_FRAC - TRIG_BITS;
    localparam int LIN_SH  = OUT_SH - TRIG_BITS;
    localparam int LP_W    = COMP_W + CS_W;                 // v * c
    localparam int LIN_W   = LP_W + LIN_SH;                 // linear term, Q30
    localparam int PH_W    = CS_W + CR_W - CR_LO_W;         // s * cross high slice
    localparam int PL_W    = CS_W + CR_LO_W + 1;            // s * cross low slice
    localparam int PCR_W   = CS_W + CR_W;                   // s * cross
    localparam int CRS_SH  = DOT_SH + TRIG_BITS;
    localparam int CRS_W   = PCR_W - CRS_SH + 1;            // cross term, Q30
    localparam int EP_W    = DOT_W + OM_W;                  // dot * (1 - cos)
    localparam int E_W     = EP_W - TRIG_BITS + 1;          // e, Q30
    localparam int EL_W    = E_W / 2;
    localparam int EH_W    = E_W - EL_W;
    localparam int AH_W    = COMP_W + EH_W;
    localparam int AL_W    = COMP_W + EL_W + 1;
    localparam int AXP_W   = COMP_W + E_W;                  // k * e
    localparam int AX_W    = AXP_W - Q30_FRAC + 1;          // axial term, Q30
    localparam int LC_W    = ((LIN_W > CRS_W) ? LIN_W : CRS_W) + 1;
    localparam int SUM_W   = ((LC_W > AX_W) ? LC_W : AX_W) + 1;

    localparam logic signed [CORDIC_W-1:0] RND_TRIG = CORDIC_W'(1) << (TRIG_SH - 1);
    localparam logic signed [OM_W-1:0]     ONE_TRIG = OM_W'(1) << TRIG_BITS;

    // Stage map
    localparam int ST_A = N_CORDIC + 1;   // cos/sin, k*v products
    localparam int ST_B = N_CORDIC + 2;   // cross, dot terms, linear term
    localparam int ST_C = N_CORDIC + 3;   // dot sum, s*cross slices
    localparam int ST_D = N_CORDIC + 4;   // dot*(1-cos), s*cross
    localparam int ST_E = N_CORDIC + 5;   // rounded e and cross term
    localparam int ST_F = N_CORDIC + 6;   // k*e slices, lin+cross
    localparam int ST_G = N_CORDIC + 7;   // k*e
    localparam int ST_H = N_CORDIC + 8;   // axial term
    localparam int ST_I = N_CORDIC + 9;   // total
    localparam int ST_J = N_CORDIC + 10;  // rounded, saturated output word
    localparam int N_ST = N_CORDIC + 11;

    // ---------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or everything after it moves
    // ---------------------------------------------------------------------
    logic [N_ST-1:0] r_vld;
    logic [N_ST-1:0] w_en;

    for (genvar g = 0; g < N_ST; g++) begin : g_en
        assign w_en[g] = m_axis_tready | ~(&r_vld[N_ST-1:g]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < N_ST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_vld[ST_J];

    // ---------------------------------------------------------------------
    // Input register and CORDIC chain; k, v and flags ride alongside
    // ---------------------------------------------------------------------
    logic signed [CORDIC_W-1:0] r_cx   [0:N_CORDIC];
    logic signed [CORDIC_W-1:0] r_cy   [0:N_CORDIC];
    logic signed [CORDIC_W-1:0] r_cz   [0:N_CORDIC];
    t_quad                      r_quad [0:N_CORDIC];
    logic                       r_rz   [0:N_CORDIC];   // remainder zero: exact cos=1, sin=0
    logic                       r_zero [0:N_CORDIC];   // zero axis
    logic signed [COMP_W-1:0]   r_k    [0:N_CORDIC][0:2];
    logic signed [COMP_W-1:0]   r_pv   [0:N_CORDIC][0:2];

    logic [REM_W-1:0] w_rem;
    assign w_rem = s_axis_tdata[6*COMP_W +: REM_W];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_k[0][i]  <= s_axis_tdata[i*COMP_W +: COMP_W];
                r_pv[0][i] <= s_axis_tdata[(3+i)*COMP_W +: COMP_W];
            end
            r_cx[0]   <= CORDIC_GAIN;
            r_cy[0]   <= '0;
            r_cz[0]   <= CORDIC_W'({w_rem, {Z_SHIFT{1'b0}}});
            r_quad[0] <= t_quad'(s_axis_tdata[6*COMP_W+REM_W +: 2]);
            r_rz[0]   <= (w_rem == '0);
            r_zero[0] <= (s_axis_tdata[3*COMP_W-1:0] == '0);
        end
    end

    // One rotation step per stage; the angle accumulator sign picks the direction.
    for (genvar j = 1; j <= N_CORDIC; j++) begin : g_cordic
        logic signed [CORDIC_W-1:0] w_dx;
        logic signed [CORDIC_W-1:0] w_dy;
        logic signed [CORDIC_W-1:0] w_at;

        assign w_dx = r_cy[j-1] >>> (j - 1);
        assign w_dy = r_cx[j-1] >>> (j - 1);
        assign w_at = CORDIC_W'(ATAN_TURNS[j-1]);

        always_ff @(posedge i_clk) begin
            if (w_en[j]) begin
                if (!r_cz[j-1][CORDIC_W-1]) begin
                    r_cx[j] <= r_cx[j-1] - w_dx;
                    r_cy[j] <= r_cy[j-1] + w_dy;
                    r_cz[j] <= r_cz[j-1] - w_at;
                end else begin
                    r_cx[j] <= r_cx[j-1] + w_dx;
                    r_cy[j] <= r_cy[j-1] - w_dy;
                    r_cz[j] <= r_cz[j-1] + w_at;
                end
                r_quad[j] <= r_quad[j-1];
                r_rz[j]   <= r_rz[j-1];
                r_zero[j] <= r_zero[j-1];
                r_k[j]    <= r_k[j-1];
                r_pv[j]   <= r_pv[j-1];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage A: round to Q1.TRIG_BITS, map quadrant; all nine k_i*v_j
    // ---------------------------------------------------------------------
    logic signed [CORDIC_W-1:0] w_xs, w_ys, w_xr, w_yr;
    logic signed [CS_W-1:0]     w_c, w_s, w_cq, w_sq;

    always_comb begin
        w_xs = r_rz[N_CORDIC] ? ONE_Q30 : r_cx[N_CORDIC];
        w_ys = r_rz[N_CORDIC] ? '0      : r_cy[N_CORDIC];
        w_xr = (w_xs + RND_TRIG) >>> TRIG_SH;
        w_yr = (w_ys + RND_TRIG) >>> TRIG_SH;
        w_c  = w_xr[CS_W-1:0];
        w_s  = w_yr[CS_W-1:0];
        case (r_quad[N_CORDIC])
            QUAD_I:   begin w_cq = w_c;  w_sq = w_s;  end
            QUAD_II:  begin w_cq = -w_s; w_sq = w_c;  end
            QUAD_III: begin w_cq = -w_c; w_sq = -w_s; end
            QUAD_IV:  begin w_cq = w_s;  w_sq = -w_c; end
            default:  begin w_cq = w_c;  w_sq = w_s;  end
        endcase
    end

    logic signed [CS_W-1:0]   r_a_c, r_a_s;
    logic signed [KV_W-1:0]   r_a_kv [0:2][0:2];
    logic signed [COMP_W-1:0] r_a_k  [0:2];
    logic signed [COMP_W-1:0] r_a_v  [0:2];
    logic                     r_a_zero;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_A]) begin
            r_a_c    <= w_cq;
            r_a_s    <= w_sq;
            r_a_zero <= r_zero[N_CORDIC];
            for (int i = 0; i < 3; i++) begin
                r_a_k[i] <= r_k[N_CORDIC][i];
                r_a_v[i] <= r_pv[N_CORDIC][i];
                for (int m = 0; m < 3; m++) begin
                    r_a_kv[i][m] <= r_k[N_CORDIC][i] * r_pv[N_CORDIC][m];
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage B: cross product (Q46), rounded dot terms, v*cos, 1-cos
    // ---------------------------------------------------------------------
    logic signed [LP_W-1:0] w_lin_p [0:2];
    logic signed [OM_W-1:0] w_om;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_lin_p[i] = r_a_v[i] * r_a_c;
        end
        w_om = ONE_TRIG - OM_W'(r_a_c);
    end

    logic signed [CR_W-1:0]   r_b_cr  [0:2];
    logic signed [DT_W-1:0]   r_b_dt  [0:2];
    logic signed [LIN_W-1:0]  r_b_lin [0:2];
    logic signed [CS_W-1:0]   r_b_s;
    logic signed [OM_W-1:0]   r_b_om;
    logic signed [COMP_W-1:0] r_b_k   [0:2];
    logic                     r_b_zero;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_B]) begin
            r_b_cr[0] <= CR_W'(r_a_kv[1][2]) - CR_W'(r_a_kv[2][1]);
            r_b_cr[1] <= CR_W'(r_a_kv[2][0]) - CR_W'(r_a_kv[0][2]);
            r_b_cr[2] <= CR_W'(r_a_kv[0][1]) - CR_W'(r_a_kv[1][0]);
            for (int i = 0; i < 3; i++) begin
                r_b_dt[i]  <= DT_W'(f_round_away(t_wide'(r_a_kv[i][i]), DOT_SH));
                r_b_lin[i] <= LIN_W'(t_wide'(w_lin_p[i]) <<< LIN_SH);
                r_b_k[i]   <= r_a_k[i];
            end
            r_b_s    <= r_a_s;
            r_b_om   <= w_om;
            r_b_zero <= r_a_zero;
        end
    end

    // ---------------------------------------------------------------------
    // Stage C: dot sum; sin * cross split into two narrower products
    // ---------------------------------------------------------------------
    logic signed [PH_W-1:0] w_ph [0:2];
    logic signed [PL_W-1:0] w_pl [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ph[i] = r_b_s * $signed(r_b_cr[i][CR_W-1:CR_LO_W]);
            w_pl[i] = r_b_s * $signed({1'b0, r_b_cr[i][CR_LO_W-1:0]});
        end
    end

    logic signed [DOT_W-1:0]  r_c_dot;
    logic signed [PH_W-1:0]   r_c_ph  [0:2];
    logic signed [PL_W-1:0]   r_c_pl  [0:2];
    logic signed [LIN_W-1:0]  r_c_lin [0:2];
    logic signed [OM_W-1:0]   r_c_om;
    logic signed [COMP_W-1:0] r_c_k   [0:2];
    logic                     r_c_zero;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_C]) begin
            r_c_dot <= DOT_W'(r_b_dt[0]) + DOT_W'(r_b_dt[1]) + DOT_W'(r_b_dt[2]);
            for (int i = 0; i < 3; i++) begin
                r_c_ph[i]  <= w_ph[i];
                r_c_pl[i]  <= w_pl[i];
                r_c_lin[i] <= r_b_lin[i];
                r_c_k[i]   <= r_b_k[i];
            end
            r_c_om   <= r_b_om;
            r_c_zero <= r_b_zero;
        end
    end

    // ---------------------------------------------------------------------
    // Stage D: dot*(1-cos); recombine sin*cross
    // ---------------------------------------------------------------------
    logic signed [EP_W-1:0] w_ep;
    assign w_ep = r_c_dot * r_c_om;

    logic signed [EP_W-1:0]   r_d_ep;
    logic signed [PCR_W-1:0]  r_d_pcr [0:2];
    logic signed [LIN_W-1:0]  r_d_lin [0:2];
    logic signed [COMP_W-1:0] r_d_k   [0:2];
    logic                     r_d_zero;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_D]) begin
            r_d_ep <= w_ep;
            for (int i = 0; i < 3; i++) begin
                r_d_pcr[i] <= PCR_W'((t_wide'(r_c_ph[i]) <<< CR_LO_W) + t_wide'(r_c_pl[i]));
                r_d_lin[i] <= r_c_lin[i];
                r_d_k[i]   <= r_c_k[i];
            end
            r_d_zero <= r_c_zero;
        end
    end

    // ---------------------------------------------------------------------
    // Stage E: round e and the cross term to Q30
    // ---------------------------------------------------------------------
    logic signed [E_W-1:0]    r_e_e30;
    logic signed [CRS_W-1:0]  r_e_crs [0:2];
    logic signed [LIN_W-1:0]  r_e_lin [0:2];
    logic signed [COMP_W-1:0] r_e_k   [0:2];
    logic                     r_e_zero;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_E]) begin
            r_e_e30 <= E_W'(f_round_away(t_wide'(r_d_ep), TRIG_BITS));
            for (int i = 0; i < 3; i++) begin
                r_e_crs[i] <= CRS_W'(f_round_away(t_wide'(r_d_pcr[i]), CRS_SH));
                r_e_lin[i] <= r_d_lin[i];
                r_e_k[i]   <= r_d_k[i];
            end
            r_e_zero <= r_d_zero;
        end
    end

    // ---------------------------------------------------------------------
    // Stage F: k*e as two slices; linear plus cross
    // ---------------------------------------------------------------------
    logic signed [AH_W-1:0] w_ah [0:2];
    logic signed [AL_W-1:0] w_al [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ah[i] = r_e_k[i] * $signed(r_e_e30[E_W-1:EL_W]);
            w_al[i] = r_e_k[i] * $signed({1'b0, r_e_e30[EL_W-1:0]});
        end
    end

    logic signed [AH_W-1:0] r_f_ah [0:2];
    logic signed [AL_W-1:0] r_f_al [0:2];
    logic signed [LC_W-1:0] r_f_lc [0:2];
    logic                   r_f_zero;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_F]) begin
            for (int i = 0; i < 3; i++) begin
                r_f_ah[i] <= w_ah[i];
                r_f_al[i] <= w_al[i];
                r_f_lc[i] <= LC_W'(r_e_lin[i]) + LC_W'(r_e_crs[i]);
            end
            r_f_zero <= r_e_zero;
        end
    end

    // ---------------------------------------------------------------------
    // Stage G: recombine k*e
    // ---------------------------------------------------------------------
    logic signed [AXP_W-1:0] r_g_pax [0:2];
    logic signed [LC_W-1:0]  r_g_lc  [0:2];
    logic                    r_g_zero;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_G]) begin
            for (int i = 0; i < 3; i++) begin
                r_g_pax[i] <= AXP_W'((t_wide'(r_f_ah[i]) <<< EL_W) + t_wide'(r_f_al[i]));
                r_g_lc[i]  <= r_f_lc[i];
            end
            r_g_zero <= r_f_zero;
        end
    end

    // ---------------------------------------------------------------------
    // Stage H: axial term rounded to Q30
    // ---------------------------------------------------------------------
    logic signed [AX_W-1:0] r_h_ax [0:2];
    logic signed [LC_W-1:0] r_h_lc [0:2];
    logic                   r_h_zero;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_H]) begin
            for (int i = 0; i < 3; i++) begin
                r_h_ax[i] <= AX_W'(f_round_away(t_wide'(r_g_pax[i]), Q30_FRAC));
                r_h_lc[i] <= r_g_lc[i];
            end
            r_h_zero <= r_g_zero;
        end
    end

    // ---------------------------------------------------------------------
    // Stage I: sum of the three Q30 terms
    // ---------------------------------------------------------------------
    logic signed [SUM_W-1:0] r_i_sum [0:2];
    logic                    r_i_zero;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_I]) begin
            for (int i = 0; i < 3; i++) begin
                r_i_sum[i] <= SUM_W'(r_h_ax[i]) + SUM_W'(r_h_lc[i]);
            end
            r_i_zero <= r_h_zero;
        end
    end

    // ---------------------------------------------------------------------
    // Stage J: round to Q16, clamp to 32 bits; zero axis forces an all-zero word
    // ---------------------------------------------------------------------
    t_wide             w_rnd [0:2];
    logic [COMP_W-1:0] w_res [0:2];
    logic [2:0]        w_clamp;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rnd[i] = f_round_away(t_wide'(r_i_sum[i]), OUT_SH);
            if (!w_rnd[i][WIDE_W-1] && (|w_rnd[i][WIDE_W-2:COMP_W-1])) begin
                w_res[i]   = Q16_MAX;
                w_clamp[i] = 1'b1;
            end else if (w_rnd[i][WIDE_W-1] && !(&w_rnd[i][WIDE_W-2:COMP_W-1])) begin
                w_res[i]   = Q16_MIN;
                w_clamp[i] = 1'b1;
            end else begin
                w_res[i]   = w_rnd[i][COMP_W-1:0];
                w_clamp[i] = 1'b0;
            end
        end
    end

    logic [COMP_W-1:0] r_out [0:2];
    logic              r_out_sat;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_J]) begin
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= r_i_zero ? '0 : w_res[i];
            end
            r_out_sat <= !r_i_zero && (|w_clamp);
        end
    end

    assign m_axis_tdata = {r_out[2], r_out[1], r_out[0]};
    assign m_axis_tuser = r_out_sat;

endmodule

`default_nettype wire

@@ rtl/rpaa_checker.sv @@
// Port-level checker for the axis rotation block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "rotate_point_about_axis_defines.svh"

module rpaa_checker
    import rpaa_pkg::*;
(
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    s_axis_tready,
    input wire                    m_axis_tvalid,
    input wire                    m_axis_tready,
    input wire [OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire [OUT_TUSER_W-1:0]  m_axis_tuser
);

    logic w_stall;
    logic w_any_rail;

    assign w_stall    = m_axis_tvalid && !m_axis_tready;
    assign w_any_rail = (m_axis_tdata[COMP_W-1:0] == Q16_MAX)
                     || (m_axis_tdata[COMP_W-1:0] == Q16_MIN)
                     || (m_axis_tdata[2*COMP_W-1:COMP_W] == Q16_MAX)
                     || (m_axis_tdata[2*COMP_W-1:COMP_W] == Q16_MIN)
                     || (m_axis_tdata[3*COMP_W-1:2*COMP_W] == Q16_MAX)
                     || (m_axis_tdata[3*COMP_W-1:2*COMP_W] == Q16_MIN);

    // stalled output word stays up and unchanged
    `RPAA_ASSERT(a_out_hold, w_stall |=> m_axis_tvalid, "output word dropped while stalled")
    `RPAA_ASSERT(a_out_stable, w_stall |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)), "output word changed while stalled")

    // input side only backs off when the whole pipe is full behind a stalled word
    `RPAA_ASSERT(a_ready_full, !s_axis_tready |-> w_stall, "input refused with room in the pipe")

    // saturated flag means some component sits on a rail
    `RPAA_ASSERT(a_sat_rail, (m_axis_tvalid && m_axis_tuser[0]) |-> w_any_rail, "saturated flag without a clamped component")

    // nothing comes out right after reset
    `RPAA_ASSERT_RST(a_reset_idle, !i_rst_n |=> !m_axis_tvalid, "output valid right after reset")

endmodule

bind rotate_point_about_axis rpaa_checker u_rpaa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
